### sv/abp_pkg.sv
// ============================================================================
// abp_pkg
// Shared types, widths, constants and the arctangent table for the
// accelerometer pitch balance pipeline.
// ============================================================================
package abp_pkg;

    localparam int SAMPLE_BITS      = 10;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int AXIS_SCALE       = 6;
    localparam int OFF_W            = 13;
    localparam int THR_W            = 8;
    localparam int SCL_W            = SAMPLE_BITS + 3;
    localparam int AXIS_W           = ((SCL_W > OFF_W) ? SCL_W : OFF_W) + 1;
    localparam int MAG_W            = AXIS_W - 1;
    localparam int SQ_W             = 2 * AXIS_W;
    localparam int ROOT_W           = AXIS_W;
    localparam int PRE_SHIFT        = 16;
    localparam int CX_W             = ROOT_W + PRE_SHIFT + 2;
    localparam int ANG_W            = 26;
    localparam int PITCH_W          = 16;
    localparam int MAGQ8_W          = 15;
    localparam int TABLE_LEN        = 24;
    localparam int RIGHT_ANGLE_Q16  = 5898240;
    localparam int RIGHT_ANGLE_Q8   = 23040;
    localparam int FRONT_STAGES     = 3;
    localparam int BACK_STAGES      = 2;
    localparam int LATENCY          = FRONT_STAGES + ROOT_W + ANGLE_ITERATIONS + BACK_STAGES;

    localparam logic [OFF_W-1:0] X_OFFSET_RST = 13'd440;
    localparam logic [OFF_W-1:0] Y_OFFSET_RST = 13'd440;
    localparam logic [OFF_W-1:0] Z_OFFSET_RST = 13'd365;
    localparam logic signed [THR_W-1:0] FWD_THR_RST = 8'sd5;
    localparam logic signed [THR_W-1:0] REV_THR_RST = 8'sd5;

    typedef enum logic [2:0] {
        REG_X_OFFSET  = 3'd0,
        REG_Y_OFFSET  = 3'd1,
        REG_Z_OFFSET  = 3'd2,
        REG_FWD_THR   = 3'd3,
        REG_REV_THR   = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        DRIVE_STOP = 2'd0,
        DRIVE_FWD  = 2'd1,
        DRIVE_BACK = 2'd2
    } drive_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x_sample;
        logic [SAMPLE_BITS-1:0] y_sample;
        logic [SAMPLE_BITS-1:0] z_sample;
    } sample_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_degrees;
        logic [1:0]                drive_command;
        logic                      balanced;
    } result_t;

    typedef struct packed {
        logic [OFF_W-1:0]        x_offset;
        logic [OFF_W-1:0]        y_offset;
        logic [OFF_W-1:0]        z_offset;
        logic signed [THR_W-1:0] fwd_thr;
        logic signed [THR_W-1:0] rev_thr;
    } cfg_t;

    typedef struct packed {
        logic [MAG_W-1:0] ay;
        logic             y_neg;
        logic             y_zero;
    } side_t;

    function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/abp_front.sv
// ============================================================================
// abp_front
// Axis scaling and offset removal, squaring, and the sum of squares.
// ============================================================================
module abp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  abp_pkg::sample_t sample,
    input  abp_pkg::cfg_t    cfg,
    output logic             out_valid,
    output logic [abp_pkg::SQ_W-1:0] sum,
    output abp_pkg::side_t   side
);
    import abp_pkg::*;

    function automatic logic signed [AXIS_W-1:0] scale_axis(
        input logic [SAMPLE_BITS-1:0] s,
        input logic [OFF_W-1:0]       off
    );
        logic [AXIS_W-1:0] a;
        logic [AXIS_W-1:0] b;
        a = AXIS_W'(s) * AXIS_W'(AXIS_SCALE);
        b = AXIS_W'(off);
        return $signed(a - b);
    endfunction

    logic [FRONT_STAGES-1:0] vld_reg;

    logic signed [AXIS_W-1:0] xs_reg, ys_reg, zs_reg;
    logic [SQ_W-1:0]          xsq_reg, zsq_reg;
    side_t                    side2_reg, side3_reg;
    logic [SQ_W-1:0]          sum_reg;

    logic signed [2*AXIS_W-1:0] xsq_next, zsq_next;
    logic signed [AXIS_W-1:0]   ay_full;
    side_t                      side2_next;

    always_comb
    begin
        xsq_next = xs_reg * xs_reg;
        zsq_next = zs_reg * zs_reg;
        ay_full  = ys_reg[AXIS_W-1] ? -ys_reg : ys_reg;
        side2_next.ay     = ay_full[MAG_W-1:0];
        side2_next.y_neg  = ys_reg[AXIS_W-1];
        side2_next.y_zero = (ys_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg    <= scale_axis(sample.x_sample, cfg.x_offset);
        ys_reg    <= scale_axis(sample.y_sample, cfg.y_offset);
        zs_reg    <= scale_axis(sample.z_sample, cfg.z_offset);
        xsq_reg   <= SQ_W'(xsq_next);
        zsq_reg   <= SQ_W'(zsq_next);
        side2_reg <= side2_next;
        sum_reg   <= xsq_reg + zsq_reg;
        side3_reg <= side2_reg;
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign sum       = sum_reg;
    assign side      = side3_reg;

endmodule

### sv/abp_sqrt.sv
// ============================================================================
// abp_sqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module abp_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [abp_pkg::SQ_W-1:0] sum,
    input  abp_pkg::side_t   side_in,
    output logic             out_valid,
    output logic [abp_pkg::ROOT_W-1:0] root,
    output abp_pkg::side_t   side_out
);
    import abp_pkg::*;

    logic              vld_reg  [1:ROOT_W];
    logic [SQ_W-1:0]   rem_reg  [1:ROOT_W];
    logic [SQ_W-1:0]   root_reg [1:ROOT_W];
    side_t             side_reg [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
        logic            vld_cur;
        logic [SQ_W-1:0] rem_cur, root_cur;
        side_t           side_cur;
        logic [SQ_W-1:0] trial;
        logic [SQ_W-1:0] rem_next, root_next;

        if (k == 0)
        begin : g_head
            assign vld_cur  = in_valid;
            assign rem_cur  = sum;
            assign root_cur = '0;
            assign side_cur = side_in;
        end
        else
        begin : g_tail
            assign vld_cur  = vld_reg[k];
            assign rem_cur  = rem_reg[k];
            assign root_cur = root_reg[k];
            assign side_cur = side_reg[k];
        end

        always_comb
        begin
            trial = root_cur + BIT;
            if (rem_cur >= trial)
            begin
                rem_next  = rem_cur - trial;
                root_next = (root_cur >> 1) + BIT;
            end
            else
            begin
                rem_next  = rem_cur;
                root_next = root_cur >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            root_reg[k+1] <= root_next;
            side_reg[k+1] <= side_cur;
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign root      = root_reg[ROOT_W][ROOT_W-1:0];
    assign side_out  = side_reg[ROOT_W];

endmodule

### sv/abp_cordic.sv
// ============================================================================
// abp_cordic
// Pipelined CORDIC vectoring, one rotation per stage, angle in Q16 degrees.
// ============================================================================
module abp_cordic (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [abp_pkg::ROOT_W-1:0] root,
    input  abp_pkg::side_t   side_in,
    output logic             out_valid,
    output logic signed [abp_pkg::ANG_W-1:0] angle,
    output logic             d_zero,
    output abp_pkg::side_t   side_out
);
    import abp_pkg::*;

    localparam int N = ANGLE_ITERATIONS;

    logic                    vld_reg [1:N];
    logic signed [CX_W-1:0]  cx_reg  [1:N];
    logic signed [CX_W-1:0]  cy_reg  [1:N];
    logic signed [ANG_W-1:0] ang_reg [1:N];
    logic                    dz_reg  [1:N];
    side_t                   side_reg[1:N];

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        localparam logic signed [ANG_W-1:0] STEP = atan_q16(i);
        logic                    vld_cur, dz_cur;
        logic signed [CX_W-1:0]  cx_cur, cy_cur;
        logic signed [ANG_W-1:0] ang_cur;
        side_t                   side_cur;
        logic signed [CX_W-1:0]  cx_next, cy_next;
        logic signed [ANG_W-1:0] ang_next;

        if (i == 0)
        begin : g_head
            assign vld_cur  = in_valid;
            assign cx_cur   = $signed(CX_W'(root) << PRE_SHIFT);
            assign cy_cur   = $signed(CX_W'(side_in.ay) << PRE_SHIFT);
            assign ang_cur  = '0;
            assign dz_cur   = (root == '0);
            assign side_cur = side_in;
        end
        else
        begin : g_tail
            assign vld_cur  = vld_reg[i];
            assign cx_cur   = cx_reg[i];
            assign cy_cur   = cy_reg[i];
            assign ang_cur  = ang_reg[i];
            assign dz_cur   = dz_reg[i];
            assign side_cur = side_reg[i];
        end

        always_comb
        begin
            if (!cy_cur[CX_W-1])
            begin
                cx_next  = cx_cur + (cy_cur >>> i);
                cy_next  = cy_cur - (cx_cur >>> i);
                ang_next = ang_cur + STEP;
            end
            else
            begin
                cx_next  = cx_cur - (cy_cur >>> i);
                cy_next  = cy_cur + (cx_cur >>> i);
                ang_next = ang_cur - STEP;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            cx_reg[i+1]   <= cx_next;
            cy_reg[i+1]   <= cy_next;
            ang_reg[i+1]  <= ang_next;
            dz_reg[i+1]   <= dz_cur;
            side_reg[i+1] <= side_cur;
        end
    end

    assign out_valid = vld_reg[N];
    assign angle     = ang_reg[N];
    assign d_zero    = dz_reg[N];
    assign side_out  = side_reg[N];

endmodule

### sv/abp_back.sv
// ============================================================================
// abp_back
// Angle clamp and rounding, sign and special cases, threshold decision.
// ============================================================================
module abp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic signed [abp_pkg::ANG_W-1:0] angle,
    input  logic             d_zero,
    input  abp_pkg::side_t   side,
    input  abp_pkg::cfg_t    cfg,
    output logic             result_valid,
    output abp_pkg::result_t result
);
    import abp_pkg::*;

    localparam logic signed [ANG_W-1:0] RA_Q16 = ANG_W'(RIGHT_ANGLE_Q16);
    localparam logic signed [PITCH_W-1:0] RA_Q8 = PITCH_W'(RIGHT_ANGLE_Q8);

    logic                      vld1_reg, vld2_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    result_t                   result_reg;

    logic signed [ANG_W-1:0]   ang_c;
    logic [ANG_W-1:0]          ang_r;
    logic signed [PITCH_W-1:0] mag;
    logic signed [PITCH_W-1:0] pitch_next;
    result_t                   result_next;

    always_comb
    begin
        if (angle < 0)
            ang_c = '0;
        else if (angle > RA_Q16)
            ang_c = RA_Q16;
        else
            ang_c = angle;
        ang_r = ($unsigned(ang_c) + ANG_W'(128)) >> 8;
        mag   = $signed(PITCH_W'(ang_r[MAGQ8_W-1:0]));
        if (side.y_zero)
            pitch_next = '0;
        else if (d_zero)
            pitch_next = side.y_neg ? -RA_Q8 : RA_Q8;
        else
            pitch_next = side.y_neg ? -mag : mag;
    end

    always_comb
    begin
        result_next.pitch_degrees = pitch_reg;
        if (pitch_reg > $signed({cfg.fwd_thr, 8'h00}))
        begin
            result_next.drive_command = DRIVE_FWD;
            result_next.balanced      = 1'b0;
        end
        else if (pitch_reg < $signed({cfg.rev_thr, 8'h00}))
        begin
            result_next.drive_command = DRIVE_BACK;
            result_next.balanced      = 1'b0;
        end
        else
        begin
            result_next.drive_command = DRIVE_STOP;
            result_next.balanced      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pitch_reg  <= pitch_next;
        result_reg <= result_next;
    end

    assign result_valid = vld2_reg;
    assign result       = result_reg;

endmodule

### sv/accelerometer_pitch_balance.sv
// ============================================================================
// accelerometer_pitch_balance
// Accelerometer pitch (atan2 via square root and CORDIC) with a balance
// drive decision from forward and reverse thresholds.
// ============================================================================
// Channel  | Ports                        | Transaction
// ---------+------------------------------+------------------------------------
// input    | start, busy, sample          | start high and busy low at clk edge
// result   | result_valid, result         | one-cycle strobe, no backpressure
// config   | wr_en, wr_index, wr_data     | write at clk edge with wr_en high
//
// One sample per cycle; busy stays low.
// The pipeline has 3 front stages, 14 square root bits, 16 CORDIC rotations
// and 2 output stages. Depth set by the root width and rotation count.
// Reset clears valid bits and restores register defaults; nothing stalls.
// ============================================================================
module accelerometer_pitch_balance (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  abp_pkg::sample_t           sample,
    output logic                       result_valid,
    output abp_pkg::result_t           result,
    input  logic                       wr_en,
    input  logic [2:0]                 wr_index,
    input  logic [abp_pkg::OFF_W-1:0]  wr_data
);
    import abp_pkg::*;

    cfg_t cfg_reg;

    logic             f_valid, s_valid, c_valid;
    logic [SQ_W-1:0]  f_sum;
    side_t            f_side, s_side, c_side;
    logic [ROOT_W-1:0] s_root;
    logic signed [ANG_W-1:0] c_angle;
    logic             c_dz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_offset <= X_OFFSET_RST;
            cfg_reg.y_offset <= Y_OFFSET_RST;
            cfg_reg.z_offset <= Z_OFFSET_RST;
            cfg_reg.fwd_thr  <= FWD_THR_RST;
            cfg_reg.rev_thr  <= REV_THR_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_X_OFFSET: cfg_reg.x_offset <= wr_data;
                REG_Y_OFFSET: cfg_reg.y_offset <= wr_data;
                REG_Z_OFFSET: cfg_reg.z_offset <= wr_data;
                REG_FWD_THR:  cfg_reg.fwd_thr  <= $signed(wr_data[THR_W-1:0]);
                REG_REV_THR:  cfg_reg.rev_thr  <= $signed(wr_data[THR_W-1:0]);
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    abp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .sample    (sample),
        .cfg       (cfg_reg),
        .out_valid (f_valid),
        .sum       (f_sum),
        .side      (f_side)
    );

    abp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .sum       (f_sum),
        .side_in   (f_side),
        .out_valid (s_valid),
        .root      (s_root),
        .side_out  (s_side)
    );

    abp_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .root      (s_root),
        .side_in   (s_side),
        .out_valid (c_valid),
        .angle     (c_angle),
        .d_zero    (c_dz),
        .side_out  (c_side)
    );

    abp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (c_valid),
        .angle        (c_angle),
        .d_zero       (c_dz),
        .side         (c_side),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### sv/abp_checker.sv
// ============================================================================
// abp_checker
// Port-level checks on the pitch balance block, bound to the top level.
// ============================================================================
module abp_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             result_valid,
    input  abp_pkg::result_t result
);
    import abp_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching input transaction");

    a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.balanced == (result.drive_command == DRIVE_STOP)))
        else $error("balanced does not match stop command");

    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.drive_command == DRIVE_STOP
                       || result.drive_command == DRIVE_FWD
                       || result.drive_command == DRIVE_BACK))
        else $error("illegal drive command");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pitch_degrees >= -16'sd23040
                       && result.pitch_degrees <= 16'sd23040))
        else $error("pitch out of range");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind accelerometer_pitch_balance abp_checker u_abp_checker (.*);
